// ===== rtl/gas_sensor_ppm_converter_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the gas sensor ppm converter
// Same-cycle and next-cycle implication checks on clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef GAS_SENSOR_PPM_CONVERTER_TOP_MACROS_SVH
`define GAS_SENSOR_PPM_CONVERTER_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GSPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define GSPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gspc_pkg.sv =====
// ----------------------------------------------------------------------------
// gspc_pkg
// Constants, status codes and the exp2 root table for the ppm converter.
// ----------------------------------------------------------------------------
package gspc_pkg;

    localparam int ADC_BITS  = 12;
    localparam int FRAC_BITS = 12;
    localparam logic [ADC_BITS-1:0] ADC_FULL = {ADC_BITS{1'b1}};

    localparam logic [17:0] LOG2_A_Q12 = 18'd37937;   // log2(613.9) in Q12
    localparam logic [13:0] EXPO_Q12   = 14'd8495;    // 2.074 in Q12
    localparam logic [31:0] EXPO_HALF  = 32'd4247;
    // ceil(2^42 / 8495): exact quotient by 8495 for dividends below 2^28
    localparam logic [28:0] EXPO_RECIP = 29'd517721779;
    localparam logic [19:0] PPM_MAX    = 20'hFFFFF;

    // register indexes
    localparam logic [1:0] CFG_CAL_WINDOW = 2'd0;
    localparam logic [1:0] CFG_LOAD_RES   = 2'd1;
    localparam logic [1:0] CFG_CAL_PPM    = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_CAL   = 3'd1;
    localparam logic [2:0] ST_ZERO  = 3'd2;
    localparam logic [2:0] ST_NOCAL = 3'd3;
    localparam logic [2:0] ST_SAT   = 3'd4;

    // round(2^30 * 2^(2^-(k+1)))
    function automatic logic [30:0] root_q30(input logic [3:0] k);
        logic [30:0] r;
        case (k)
            4'd0:    r = 31'd1518500250;
            4'd1:    r = 31'd1276901417;
            4'd2:    r = 31'd1170923762;
            4'd3:    r = 31'd1121280436;
            4'd4:    r = 31'd1097253708;
            4'd5:    r = 31'd1085434106;
            4'd6:    r = 31'd1079572136;
            4'd7:    r = 31'd1076653033;
            4'd8:    r = 31'd1075196443;
            4'd9:    r = 31'd1074468887;
            4'd10:   r = 31'd1074105295;
            4'd11:   r = 31'd1073923544;
            default: r = 31'd1073741824;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/gas_sensor_ppm_converter_top.sv =====
// ----------------------------------------------------------------------------
// gas_sensor_ppm_converter_top
// Sample to ppm converter: serial divider, with log2 and exp2 on one shared multiplier.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                fields
//  in        input      in_valid / in_stall      adc_sample, uptime_ms
//  out       output     out_valid / out_stall    ppm, status
//  cfg       input      cfg_write_en             cfg_index, cfg_data
//
//  A request runs a serial resistance divide, then for each log2 normalize
//  shifts and squaring steps on the shared 32x32 multiplier; calibration adds
//  a reciprocal multiply for the exponent and a measurement a multiply by it;
//  both then run exp2 multiply steps and a final shift. Zero samples skip to
//  the output. in_stall is high until the sequencer idles. A held result
//  waits in the output register; reset clears control and calibration.
// ----------------------------------------------------------------------------
`include "gas_sensor_ppm_converter_top_macros.svh"

module gas_sensor_ppm_converter_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [11:0] adc_sample,
    input  logic [31:0] uptime_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [19:0] ppm,
    output logic [2:0]  status,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import gspc_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIV    = 4'd1;
    localparam logic [3:0] S_LNORM  = 4'd2;
    localparam logic [3:0] S_LSQ    = 4'd3;
    localparam logic [3:0] S_QMUL   = 4'd4;
    localparam logic [3:0] S_QADD   = 4'd5;
    localparam logic [3:0] S_EMUL   = 4'd6;
    localparam logic [3:0] S_ESHIFT = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;
    localparam logic [3:0] S_TMUL   = 4'd9;

    localparam logic [2:0] P_RS    = 3'd0;
    localparam logic [2:0] P_LCAL  = 3'd1;
    localparam logic [2:0] P_T     = 3'd2;
    localparam logic [2:0] P_LRS_C = 3'd3;
    localparam logic [2:0] P_EXP_C = 3'd4;
    localparam logic [2:0] P_LRS_M = 3'd5;
    localparam logic [2:0] P_LR0   = 3'd6;
    localparam logic [2:0] P_EXP_M = 3'd7;

    logic [3:0]  state_reg;
    logic [2:0]  phase_reg;
    logic [15:0] cal_window_reg;
    logic [7:0]  load_res_reg;
    logic [15:0] cal_ppm_reg;
    logic [31:0] r0_reg;
    logic        calibrated_reg;
    logic        in_win_reg;
    logic [31:0] rs_reg;
    logic [16:0] la_reg;
    logic        dneg_reg;
    logic [16:0] mag_reg;
    logic [30:0] qprod_reg;
    // divider
    logic [31:0] dq_reg;
    logic [13:0] drem_reg;
    logic [13:0] dden_reg;
    logic [5:0]  dcnt_reg;
    // log2
    logic [31:0] lx_reg;
    logic [4:0]  le_reg;
    logic [11:0] lfr_reg;
    logic [30:0] lm_reg;
    logic [3:0]  lcnt_reg;
    // exp2
    logic signed [20:0] ey_reg;
    logic [30:0] em_reg;
    logic [3:0]  ecnt_reg;
    // result
    logic [19:0] res_ppm_reg;
    logic [2:0]  res_status_reg;
    logic        out_valid_reg;
    logic [19:0] ppm_reg;
    logic [2:0]  status_reg;

    // shared multiplier
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;

    always_comb
    begin
        case (state_reg)
            S_LSQ:
            begin
                mul_a = {1'b0, lm_reg};
                mul_b = {1'b0, lm_reg};
            end
            S_EMUL:
            begin
                mul_a = {1'b0, em_reg};
                mul_b = {1'b0, root_q30(ecnt_reg)};
            end
            S_QMUL:
            begin
                mul_a = {15'd0, mag_reg};
                mul_b = {18'd0, EXPO_Q12};
            end
            S_TMUL:
            begin
                mul_a = dq_reg;
                mul_b = {3'd0, EXPO_RECIP};
            end
            default:
            begin
                mul_a = {24'd0, load_res_reg};
                mul_b = {20'd0, ADC_FULL - adc_sample};
            end
        endcase
        prod = mul_a * mul_b;
    end

    // divider step
    logic [14:0] dtrial;
    logic        dbit;
    assign dtrial = {drem_reg, dq_reg[31]};
    assign dbit   = (dtrial >= {1'b0, dden_reg});

    // log2 squaring step and result
    logic [31:0] sq;
    logic [16:0] lval;
    assign sq   = prod[61:30];
    assign lval = {le_reg, lfr_reg};

    // log difference for the two dispatch points
    logic [17:0] dcal;
    logic [17:0] dmeas;
    assign dcal  = {1'b0, lval} - LOG2_A_Q12;
    assign dmeas = {1'b0, la_reg} - {1'b0, lval};

    // exp2 final shift
    logic signed [8:0] en;
    logic [9:0]  sr;
    logic [4:0]  sr5;
    logic [32:0] rsum;
    logic [31:0] ev;
    logic        ebig;
    assign en  = ey_reg[20:12];
    assign sr  = 10'sd30 - {en[8], en};
    assign sr5 = sr[4:0];
    assign rsum = {2'b00, em_reg} + (33'd1 << (sr5 - 5'd1));

    always_comb
    begin
        ebig = 1'b0;
        ev   = 32'd0;
        if (en > 9'sd31)
            ebig = 1'b1;
        else if (en == 9'sd31)
            ev = {em_reg, 1'b0};
        else if (en == 9'sd30)
            ev = {1'b0, em_reg};
        else if (sr < 10'd32)
            ev = 32'(rsum >> sr5);
    end

    logic [31:0] qsum;
    assign qsum = {1'b0, qprod_reg} + 32'd2048;

    logic [20:0] y_cal;
    logic [20:0] y_meas;
    assign y_cal  = dneg_reg ? ({4'd0, lval} - {6'd0, dq_reg[14:0]})
                             : ({4'd0, lval} + {6'd0, dq_reg[14:0]});
    assign y_meas = dneg_reg ? ({3'd0, LOG2_A_Q12} + {1'b0, qsum[31:12]})
                             : ({3'd0, LOG2_A_Q12} - {1'b0, qsum[31:12]});

    logic in_acc;
    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= P_RS;
            cal_window_reg <= 16'd3000;
            load_res_reg   <= 8'd5;
            cal_ppm_reg    <= 16'd20;
            r0_reg         <= 32'd0;
            calibrated_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_CAL_WINDOW: cal_window_reg <= cfg_data;
                    CFG_LOAD_RES:   load_res_reg   <= cfg_data[7:0];
                    CFG_CAL_PPM:    cal_ppm_reg    <= cfg_data;
                    default:        ;
                endcase
            end

            // S_OUT reloads the output register itself
            if (out_valid_reg && !out_stall && state_reg != S_OUT)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        in_win_reg <= (uptime_ms < {16'd0, cal_window_reg});
                        if (adc_sample == 12'd0)
                        begin
                            res_ppm_reg    <= 20'd0;
                            res_status_reg <= ST_ZERO;
                            state_reg      <= S_OUT;
                        end
                        else
                        begin
                            dq_reg    <= 32'(prod[19:0]) << FRAC_BITS;
                            drem_reg  <= 14'd0;
                            dden_reg  <= {2'b00, adc_sample};
                            dcnt_reg  <= 6'd0;
                            phase_reg <= P_RS;
                            state_reg <= S_DIV;
                        end
                    end
                end

                S_DIV:
                begin
                    if (!dcnt_reg[5])
                    begin
                        drem_reg <= dbit ? 14'(dtrial - {1'b0, dden_reg}) : dtrial[13:0];
                        dq_reg   <= {dq_reg[30:0], dbit};
                        dcnt_reg <= dcnt_reg + 6'd1;
                    end
                    else
                    begin
                        rs_reg <= dq_reg;
                        if (in_win_reg)
                        begin
                            if (dq_reg == 32'd0 || cal_ppm_reg == 16'd0)
                            begin
                                r0_reg         <= 32'd0;
                                calibrated_reg <= 1'b1;
                                res_ppm_reg    <= {4'd0, cal_ppm_reg};
                                res_status_reg <= ST_CAL;
                                state_reg      <= S_OUT;
                            end
                            else
                            begin
                                lx_reg    <= {16'd0, cal_ppm_reg};
                                le_reg    <= 5'd31;
                                lfr_reg   <= 12'd0;
                                phase_reg <= P_LCAL;
                                state_reg <= S_LNORM;
                            end
                        end
                        else if (!calibrated_reg || r0_reg == 32'd0)
                        begin
                            res_ppm_reg    <= 20'd0;
                            res_status_reg <= ST_NOCAL;
                            state_reg      <= S_OUT;
                        end
                        else if (dq_reg == 32'd0)
                        begin
                            res_ppm_reg    <= PPM_MAX;
                            res_status_reg <= ST_SAT;
                            state_reg      <= S_OUT;
                        end
                        else
                        begin
                            lx_reg    <= dq_reg;
                            le_reg    <= 5'd31;
                            lfr_reg   <= 12'd0;
                            phase_reg <= P_LRS_M;
                            state_reg <= S_LNORM;
                        end
                    end
                end

                S_TMUL:
                begin
                    // t is done, now log2 of the resistance
                    dq_reg    <= {17'd0, prod[56:42]};
                    lx_reg    <= rs_reg;
                    le_reg    <= 5'd31;
                    lfr_reg   <= 12'd0;
                    phase_reg <= P_LRS_C;
                    state_reg <= S_LNORM;
                end

                S_LNORM:
                begin
                    if (lx_reg[31] || le_reg == 5'd0)
                    begin
                        lm_reg    <= lx_reg[31:1];
                        lcnt_reg  <= 4'd0;
                        state_reg <= S_LSQ;
                    end
                    else
                    begin
                        lx_reg <= {lx_reg[30:0], 1'b0};
                        le_reg <= le_reg - 5'd1;
                    end
                end

                S_LSQ:
                begin
                    if (lcnt_reg != 4'd12)
                    begin
                        lfr_reg  <= {lfr_reg[10:0], sq[31]};
                        lm_reg   <= sq[31] ? sq[31:1] : sq[30:0];
                        lcnt_reg <= lcnt_reg + 4'd1;
                    end
                    else
                    begin
                        case (phase_reg)
                            P_LCAL:
                            begin
                                // rounded dividend for the divide by 2.074
                                dneg_reg  <= dcal[17];
                                dq_reg    <= ({15'd0, (dcal[17] ? 17'(-dcal) : dcal[16:0])}
                                              << 12) + EXPO_HALF;
                                phase_reg <= P_T;
                                state_reg <= S_TMUL;
                            end
                            P_LRS_C:
                            begin
                                ey_reg    <= y_cal;
                                em_reg    <= 31'h40000000;
                                ecnt_reg  <= 4'd0;
                                phase_reg <= P_EXP_C;
                                state_reg <= S_EMUL;
                            end
                            P_LRS_M:
                            begin
                                la_reg    <= lval;
                                lx_reg    <= r0_reg;
                                le_reg    <= 5'd31;
                                lfr_reg   <= 12'd0;
                                phase_reg <= P_LR0;
                                state_reg <= S_LNORM;
                            end
                            default:
                            begin
                                dneg_reg  <= dmeas[17];
                                mag_reg   <= dmeas[17] ? 17'(-dmeas) : dmeas[16:0];
                                state_reg <= S_QMUL;
                            end
                        endcase
                    end
                end

                S_QMUL:
                begin
                    qprod_reg <= prod[30:0];
                    state_reg <= S_QADD;
                end

                S_QADD:
                begin
                    ey_reg    <= y_meas;
                    em_reg    <= 31'h40000000;
                    ecnt_reg  <= 4'd0;
                    phase_reg <= P_EXP_M;
                    state_reg <= S_EMUL;
                end

                S_EMUL:
                begin
                    if (ecnt_reg == 4'd12)
                        state_reg <= S_ESHIFT;
                    else
                    begin
                        if (ey_reg[4'd11 - ecnt_reg])
                            em_reg <= prod[60:30];
                        ecnt_reg <= ecnt_reg + 4'd1;
                    end
                end

                S_ESHIFT:
                begin
                    if (phase_reg == P_EXP_C)
                    begin
                        r0_reg         <= ebig ? 32'hFFFFFFFF : ev;
                        calibrated_reg <= 1'b1;
                        res_ppm_reg    <= {4'd0, cal_ppm_reg};
                        res_status_reg <= ST_CAL;
                    end
                    else if (ebig || ev > {12'd0, PPM_MAX})
                    begin
                        res_ppm_reg    <= PPM_MAX;
                        res_status_reg <= ST_SAT;
                    end
                    else
                    begin
                        res_ppm_reg    <= ev[19:0];
                        res_status_reg <= ST_OK;
                    end
                    state_reg <= S_OUT;
                end

                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        ppm_reg       <= res_ppm_reg;
                        status_reg    <= res_status_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign ppm       = ppm_reg;
    assign status    = status_reg;

    `GSPC_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_reg != S_IDLE, "request not started")
    `GSPC_ASSERT_NEXT(a_held_result_waits,
        state_reg == S_OUT && out_valid && out_stall, state_reg == S_OUT,
        "held result overwritten")
    `GSPC_ASSERT_NOW(a_sat_is_max, out_valid && status == ST_SAT, ppm == PPM_MAX,
        "saturated ppm not max")
    `GSPC_ASSERT_NOW(a_flag_ppm_zero,
        out_valid && (status == ST_ZERO || status == ST_NOCAL), ppm == 20'd0,
        "flagged ppm not zero")

endmodule
